[rtl/named_handle_table_assert.svh]
`ifndef NAMED_HANDLE_TABLE_ASSERT_SVH
`define NAMED_HANDLE_TABLE_ASSERT_SVH

// clocked check, quiet while reset is held
`define NHT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication form of the above
`define NHT_ASSERT_IMP(lbl, ante, cons, msg) \
  `NHT_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

[rtl/nht_pkg.sv]
package nht_pkg;

  localparam int KEY_W           = 56;
  localparam int HIN_W           = 32;
  localparam int HOUT_W          = 32;
  localparam int HEXT_W          = 64;
  localparam int CMD_W           = 2;
  localparam int ST_W            = 2;
  localparam int CNT_W           = 6;
  localparam int CNT_EXT_W       = 16;
  localparam int ENTRIES_DEF     = 32;
  localparam int HANDLE_BITS_DEF = 32;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL = 2'd1;
  localparam logic [ST_W-1:0] ST_MISS = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    logic [HIN_W-1:0] handle_in;
  } req_t;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [HOUT_W-1:0] handle_out;
    logic [CNT_W-1:0]  entry_count;
  } rsp_t;

endpackage

[rtl/named_handle_table.sv]
// Table of up to ENTRIES (56-bit name key, handle) pairs, searched from the
// lowest entry up. One request is taken at a time and gives one response.
// Insert and clear pass through their own step and then the done step, which
// offers the response. Lookup and remove walk the table memory (one read port
// and one write port) one
// entry per cycle, and remove then moves each later entry down one place per
// cycle through the same memory. The next request is taken as soon as the
// sequencer is back at its idle step, even while the previous response waits
// in the output register. The table holds no reset contents; entries are
// only read once written.
`include "named_handle_table_assert.svh"

module named_handle_table #(
  parameter int ENTRIES     = nht_pkg::ENTRIES_DEF,
  parameter int HANDLE_BITS = nht_pkg::HANDLE_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  nht_pkg::req_t in_req,
  output logic          out_valid,
  input  logic          out_stall,
  output nht_pkg::rsp_t out_rsp
);

  import nht_pkg::*;

  localparam int AW = $clog2(ENTRIES);
  localparam int FW = $clog2(ENTRIES + 1);
  localparam int DW = KEY_W + HANDLE_BITS;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INS   = 3'd1;
  localparam logic [2:0] S_CLR   = 3'd2;
  localparam logic [2:0] S_LSCAN = 3'd3;
  localparam logic [2:0] S_RSCAN = 3'd4;
  localparam logic [2:0] S_SHIFT = 3'd5;
  localparam logic [2:0] S_DEC   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  localparam logic [2:0] C_DISPATCH = 3'd0;
  localparam logic [2:0] C_GO       = 3'd1;
  localparam logic [2:0] C_SCAN     = 3'd2;
  localparam logic [2:0] C_SHIFT    = 3'd3;
  localparam logic [2:0] C_EMIT     = 3'd4;

  typedef struct packed {
    logic [2:0] cond;
    logic [2:0] tgt;
    logic       ins;
    logic       clr;
    logic       ld_hout;
    logic       inc_hit;
    logic       dec;
  } ucode_t;

  function automatic ucode_t ucode_rom(input logic [2:0] a);
    ucode_t w;
    w = '0;
    case (a)
      S_IDLE:  begin w.cond = C_DISPATCH; end
      S_INS:   begin w.cond = C_GO;    w.tgt = S_DONE;  w.ins = 1'b1; end
      S_CLR:   begin w.cond = C_GO;    w.tgt = S_DONE;  w.clr = 1'b1; end
      S_LSCAN: begin w.cond = C_SCAN;  w.tgt = S_DONE;  w.ld_hout = 1'b1; end
      S_RSCAN: begin w.cond = C_SCAN;  w.tgt = S_SHIFT; w.inc_hit = 1'b1; end
      S_SHIFT: begin w.cond = C_SHIFT; w.tgt = S_DEC; end
      S_DEC:   begin w.cond = C_GO;    w.tgt = S_DONE;  w.dec = 1'b1; end
      S_DONE:  begin w.cond = C_EMIT;  w.tgt = S_IDLE; end
      default: begin w.cond = C_GO;    w.tgt = S_IDLE; end
    endcase
    return w;
  endfunction

  function automatic logic [2:0] dispatch_map(input logic [CMD_W-1:0] c);
    logic [2:0] s;
    case (c)
      CMD_INSERT: s = S_INS;
      CMD_REMOVE: s = S_RSCAN;
      CMD_LOOKUP: s = S_LSCAN;
      CMD_CLEAR:  s = S_CLR;
      default:    s = S_CLR;
    endcase
    return s;
  endfunction

  logic [2:0]        upc_r, upc_nxt;
  logic [FW-1:0]     fill_r, fill_nxt;
  logic [FW-1:0]     ptr_r, ptr_nxt;
  logic [ST_W-1:0]   st_r, st_nxt;
  logic [HOUT_W-1:0] hout_r, hout_nxt;
  logic [KEY_W-1:0]  key_r;
  logic [HIN_W-1:0]  hin_r;
  logic              out_valid_r, out_valid_nxt;
  rsp_t              out_rsp_r;

  ucode_t            uw;
  logic              take, emit, scan_end, hit;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [DW-1:0]     wr_data, rd_data;
  logic [HEXT_W-1:0] hin_ext, hrd_ext;
  logic [CNT_EXT_W-1:0] cnt_ext;

  nht_ram #(
    .WIDTH (DW),
    .DEPTH (ENTRIES)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (ptr_nxt[AW-1:0]),
    .rdata (rd_data)
  );

  assign hin_ext  = HEXT_W'(hin_r);
  assign hrd_ext  = HEXT_W'(rd_data[HANDLE_BITS-1:0]);
  assign scan_end = (ptr_r >= fill_r);
  assign hit      = (rd_data[DW-1 -: KEY_W] == key_r);
  assign in_stall = (upc_r != S_IDLE);
  assign cnt_ext  = CNT_EXT_W'(fill_r);

  always_comb begin
    uw        = ucode_rom(upc_r);
    upc_nxt   = upc_r;
    fill_nxt  = fill_r;
    ptr_nxt   = ptr_r;
    st_nxt    = st_r;
    hout_nxt  = hout_r;
    take      = 1'b0;
    emit      = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = fill_r[AW-1:0];
    wr_data   = {key_r, hin_ext[HANDLE_BITS-1:0]};

    if (uw.ins) begin
      if (fill_r >= FW'(ENTRIES)) begin
        st_nxt = ST_FULL;
      end else begin
        wr_en    = 1'b1;
        fill_nxt = fill_r + 1'b1;
      end
    end
    if (uw.clr) begin
      fill_nxt = '0;
    end
    if (uw.dec) begin
      fill_nxt = fill_r - 1'b1;
    end

    case (uw.cond)
      C_DISPATCH: begin
        ptr_nxt = '0;
        if (in_valid) begin
          take     = 1'b1;
          st_nxt   = ST_OK;
          hout_nxt = '0;
          upc_nxt  = dispatch_map(in_req.cmd);
        end
      end
      C_GO: begin
        upc_nxt = uw.tgt;
      end
      C_SCAN: begin
        if (scan_end) begin
          st_nxt  = ST_MISS;
          upc_nxt = S_DONE;
        end else if (hit) begin
          upc_nxt = uw.tgt;
          if (uw.ld_hout) begin
            hout_nxt = hrd_ext[HOUT_W-1:0];
          end
          if (uw.inc_hit) begin
            ptr_nxt = ptr_r + 1'b1;
          end
        end else begin
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      C_SHIFT: begin
        if (scan_end) begin
          upc_nxt = uw.tgt;
        end else begin
          wr_en   = 1'b1;
          wr_addr = AW'(ptr_r - 1'b1);
          wr_data = rd_data;
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      C_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          emit    = 1'b1;
          upc_nxt = uw.tgt;
        end
      end
      default: begin
        upc_nxt = S_IDLE;
      end
    endcase

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r       <= S_IDLE;
      fill_r      <= '0;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      upc_r       <= upc_nxt;
      fill_r      <= fill_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    st_r   <= st_nxt;
    hout_r <= hout_nxt;
    if (take) begin
      key_r <= in_req.key;
      hin_r <= in_req.handle_in;
    end
    if (emit) begin
      out_rsp_r.status      <= st_r;
      out_rsp_r.handle_out  <= hout_r;
      out_rsp_r.entry_count <= cnt_ext[CNT_W-1:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  `NHT_ASSERT(a_fill_bound, fill_r <= FW'(ENTRIES), "fill count above table size")
  `NHT_ASSERT_IMP(a_ptr_bound, upc_r == S_LSCAN || upc_r == S_RSCAN || upc_r == S_SHIFT, ptr_r <= fill_r, "scan pointer past fill")
  `NHT_ASSERT_IMP(a_ins_grow, upc_r == S_INS && fill_r < FW'(ENTRIES), ##1 fill_r == $past(fill_r) + 1'b1, "insert did not grow table")
  `NHT_ASSERT_IMP(a_rem_shrink, upc_r == S_DEC, ##1 fill_r == $past(fill_r) - 1'b1, "remove did not shrink table")

endmodule

[rtl/nht_ram.sv]
module nht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[verif/tb_named_handle_table.sv]
`timescale 1ns / 100ps

module tb_named_handle_table;
  import nht_pkg::*;

  localparam int TBL_DEPTH   = ENTRIES_DEF;
  localparam int DRAIN_GUARD = 48;
  localparam int POOL_SIZE   = 16;
  localparam int MAX_REPORTS = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  req_t in_req = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rsp_t out_rsp;

  logic [KEY_W-1:0]  key_tbl [TBL_DEPTH];
  logic [HOUT_W-1:0] handle_tbl [TBL_DEPTH];
  int fill = 0;
  logic [KEY_W-1:0]  key_pool [POOL_SIZE];

  rsp_t pending_rsp_q [$];
  int unsigned fail_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  named_handle_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (out_rsp)
  );

  // table behaviour: linear search from entry 0, remove shifts the tail down
  function automatic rsp_t apply_table_cmd(req_t r);
    rsp_t rsp;
    int pos;
    rsp = '0;
    pos = -1;
    if (r.cmd == CMD_REMOVE || r.cmd == CMD_LOOKUP) begin
      for (int i = 0; i < fill; i++) begin
        if (key_tbl[i] == r.key) begin
          pos = i;
          break;
        end
      end
    end
    case (r.cmd)
      CMD_INSERT: begin
        if (fill >= TBL_DEPTH) begin
          rsp.status = ST_FULL;
        end else begin
          key_tbl[fill] = r.key;
          handle_tbl[fill] = r.handle_in;
          fill++;
        end
      end
      CMD_REMOVE: begin
        if (pos < 0) begin
          rsp.status = ST_MISS;
        end else begin
          for (int j = pos; j + 1 < fill; j++) begin
            key_tbl[j] = key_tbl[j + 1];
            handle_tbl[j] = handle_tbl[j + 1];
          end
          fill--;
        end
      end
      CMD_LOOKUP: begin
        if (pos < 0) begin
          rsp.status = ST_MISS;
        end else begin
          rsp.handle_out = handle_tbl[pos];
        end
      end
      default: begin
        fill = 0;
      end
    endcase
    rsp.entry_count = CNT_W'(fill);
    return rsp;
  endfunction

  task automatic check_field(input string what, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
        $display("%0t: %s mismatch: expected 0x%0h actual 0x%0h", $time, what, want, got);
      end
    end
  endtask

  always @(posedge clk) begin
    rsp_t exp_rsp;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_rsp_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
          $display("%0t: unexpected response: expected none actual 0x%0h", $time, out_rsp);
        end
      end else begin
        exp_rsp = pending_rsp_q.pop_front();
        check_field("status", 64'(exp_rsp.status), 64'(out_rsp.status));
        check_field("handle_out", 64'(exp_rsp.handle_out), 64'(out_rsp.handle_out));
        check_field("entry_count", 64'(exp_rsp.entry_count), 64'(out_rsp.entry_count));
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                              input logic [HIN_W-1:0] handle);
    req_t r;
    r.cmd = cmd;
    r.key = key;
    r.handle_in = handle;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (in_stall);
    pending_rsp_q.push_back(apply_table_cmd(r));
  endtask

  task automatic wait_until_drained();
    in_valid <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_GUARD) @(posedge clk);
  endtask

  function automatic logic [KEY_W-1:0] rand_key();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[KEY_W-1:0];
  endfunction

  function automatic logic [HIN_W-1:0] rand_handle();
    int unsigned sel;
    sel = $urandom_range(19);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return $urandom;
  endfunction

  // often a key already held, so many removes and lookups hit
  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned sel;
    sel = $urandom_range(99);
    if (fill > 0 && sel < 45) return key_tbl[$urandom_range(fill - 1)];
    if (sel < 85) return key_pool[$urandom_range(POOL_SIZE - 1)];
    return rand_key();
  endfunction

  function automatic void refresh_key_pool();
    key_pool[0] = '0;
    key_pool[1] = '1;
    key_pool[2] = 56'h0000_0000_620061;
    key_pool[3] = 56'h0000_0000_000061;
    for (int i = 4; i < POOL_SIZE; i++) begin
      if (i[0]) begin
        key_pool[i] = rand_key();
      end else begin
        // short printable name, zero padded
        key_pool[i] = KEY_W'({8'($urandom_range(122, 97)), 8'($urandom_range(122, 97)),
                              8'($urandom_range(122, 97))});
      end
    end
  endfunction

  task automatic test_empty_table();
    send_request(CMD_LOOKUP, '0, '0);
    send_request(CMD_REMOVE, '1, '1);
    send_request(CMD_CLEAR, '0, '0);
  endtask

  task automatic test_basic_ops();
    send_request(CMD_INSERT, '0, '0);
    send_request(CMD_INSERT, '1, '1);
    // embedded zero byte: full-width compare, no cut at the first zero
    send_request(CMD_INSERT, 56'h0000_0000_620061, 32'h1234_5678);
    send_request(CMD_LOOKUP, 56'h0000_0000_000061, '1);
    send_request(CMD_LOOKUP, 56'h0000_0000_620061, '0);
    send_request(CMD_REMOVE, '0, '0);
    send_request(CMD_LOOKUP, '1, '0);
    send_request(CMD_LOOKUP, '0, '0);
  endtask

  task automatic test_duplicate_keys();
    send_request(CMD_INSERT, 56'h707564, 32'h0000_00a1);
    send_request(CMD_INSERT, 56'h707564, 32'h0000_00b2);
    send_request(CMD_LOOKUP, 56'h707564, '0);
    send_request(CMD_REMOVE, 56'h707564, '0);
    send_request(CMD_LOOKUP, 56'h707564, '0);
    send_request(CMD_REMOVE, 56'h707564, '0);
    send_request(CMD_REMOVE, 56'h707564, '0);
    send_request(CMD_CLEAR, '0, '0);
  endtask

  task automatic test_full_table();
    send_request(CMD_CLEAR, rand_key(), rand_handle());
    repeat (TBL_DEPTH) send_request(CMD_INSERT, pick_key(), rand_handle());
    repeat (3) send_request(CMD_INSERT, rand_key(), rand_handle());
    repeat (2) send_request(CMD_LOOKUP, pick_key(), rand_handle());
    send_request(CMD_REMOVE, key_tbl[$urandom_range(fill - 1)], rand_handle());
    send_request(CMD_INSERT, rand_key(), rand_handle());
    send_request(CMD_INSERT, rand_key(), rand_handle());
  endtask

  task automatic run_random_mix(input int n, input int ins_w, input int rem_w,
                                input int look_w);
    int sel;
    logic [CMD_W-1:0] cmd;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      if (sel < ins_w) cmd = CMD_INSERT;
      else if (sel < ins_w + rem_w) cmd = CMD_REMOVE;
      else if (sel < ins_w + rem_w + look_w) cmd = CMD_LOOKUP;
      else cmd = CMD_CLEAR;
      send_request(cmd, pick_key(), rand_handle());
    end
  endtask

  task automatic test_random_traffic(input int unsigned sidle, input int unsigned rstall);
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    refresh_key_pool();
    test_full_table();
    run_random_mix(168, 45, 20, 30);
    run_random_mix(168, 25, 35, 37);
    wait_until_drained();
  endtask

  initial begin
    send_idle_pct = 12;
    recv_stall_pct = 74;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_table();
    test_basic_ops();
    test_duplicate_keys();
    wait_until_drained();
    test_random_traffic(12, 74);
    test_random_traffic(74, 12);
    test_random_traffic(0, 0);
    if (fail_count == 0) begin
      $display("named_handle_table test passed");
    end else begin
      $display("named_handle_table test failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("named_handle_table test failed");
    $finish;
  end

endmodule
